### rtl/fbv_pkg.sv
// ----------------------------------------------------------------------------
// fbv_pkg: shared types and constants for the frustum box visibility core
// Request modes, result causes and the per-plane test packet.
// ----------------------------------------------------------------------------
package fbv_pkg;

  localparam int unsigned FieldBits = 32;
  localparam int unsigned Corners   = 8;
  localparam int unsigned QShift    = 16;

  typedef enum logic [1:0] {
    MODE_TEST   = 2'd0,
    MODE_PLANE  = 2'd1,
    MODE_CORNER = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CAUSE_VISIBLE = 2'd0,
    CAUSE_PLANE   = 2'd1,
    CAUSE_EXTENT  = 2'd2,
    CAUSE_RSVD    = 2'd3
  } cause_t;

  typedef struct packed {
    logic       valid;
    logic       culled;
    logic       pload;
    logic       cload;
    logic [2:0] slot;
  } ctl_t;

endpackage

### rtl/fbv_req_if.sv
// ----------------------------------------------------------------------------
// fbv_req_if: request channel of the frustum box visibility core
// Valid/ready handshake carrying one load or box-test request.
// ----------------------------------------------------------------------------
interface fbv_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  slot;
  logic signed [31:0] coef_x;
  logic signed [31:0] coef_y;
  logic signed [31:0] coef_z;
  logic signed [31:0] coef_w;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_min_z;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_max_y;
  logic signed [31:0] box_max_z;

  modport source (output valid, mode, slot, coef_x, coef_y, coef_z, coef_w,
                  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, input ready);
  modport sink (input valid, mode, slot, coef_x, coef_y, coef_z, coef_w,
                box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                box_max_z, output ready);
endinterface

### rtl/fbv_res_if.sv
// ----------------------------------------------------------------------------
// fbv_res_if: result channel of the frustum box visibility core
// Valid/ready handshake carrying one visibility verdict.
// ----------------------------------------------------------------------------
interface fbv_res_if;
  logic       valid;
  logic       ready;
  logic       visible;
  logic [1:0] cull_cause;

  modport source (output valid, visible, cull_cause, input ready);
  modport sink (input valid, visible, cull_cause, output ready);
endinterface

### rtl/fbv_plane_cell.sv
// ----------------------------------------------------------------------------
// fbv_plane_cell: one plane of the culling chain
// Holds one plane, evaluates it on the eight box corners over two stages,
// and hands the request and running cull flag to the next cell.
// ----------------------------------------------------------------------------
module fbv_plane_cell #(
  parameter int unsigned CoordBits = 32,
  parameter int unsigned Index     = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  fbv_pkg::ctl_t               ctl_in,
  input  logic signed [CoordBits-1:0] lo_in [3],
  input  logic signed [CoordBits-1:0] hi_in [3],
  output fbv_pkg::ctl_t               ctl_out,
  output logic signed [CoordBits-1:0] lo_out [3],
  output logic signed [CoordBits-1:0] hi_out [3]
);

  localparam int unsigned PBits = 2 * CoordBits;
  localparam int unsigned SBits = PBits + 3;

  logic signed [CoordBits-1:0] pa, pb, pc, pd;
  logic                        ld;
  // stage 1: products
  fbv_pkg::ctl_t               c1, c2, c2_next;
  logic signed [CoordBits-1:0] lo1 [3], hi1 [3], lo2 [3], hi2 [3];
  logic signed [PBits-1:0]     px_lo, px_hi, py_lo, py_hi, pz_lo, pz_hi;
  logic signed [SBits-1:0]     dterm;
  logic                        below [8];
  logic                        all_below;
  logic signed [SBits-1:0]     sum [8];

  assign ld = adv && ctl_in.pload && (ctl_in.slot == 3'(Index));

  always_ff @(posedge clk) begin
    if (ld) begin
      pa <= lo_in[0];
      pb <= lo_in[1];
      pc <= lo_in[2];
      pd <= hi_in[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
    end else if (adv) begin
      c1 <= ctl_in;
      c2 <= c2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo1 <= lo_in;
      hi1 <= hi_in;
      px_lo <= PBits'(pa) * PBits'(lo_in[0]);
      px_hi <= PBits'(pa) * PBits'(hi_in[0]);
      py_lo <= PBits'(pb) * PBits'(lo_in[1]);
      py_hi <= PBits'(pb) * PBits'(hi_in[1]);
      pz_lo <= PBits'(pc) * PBits'(lo_in[2]);
      pz_hi <= PBits'(pc) * PBits'(hi_in[2]);
      dterm <= SBits'(pd) <<< fbv_pkg::QShift;
      lo2 <= lo1;
      hi2 <= hi1;
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      sum[k] = SBits'(k[0] ? px_hi : px_lo) + SBits'(k[1] ? py_hi : py_lo)
             + SBits'(k[2] ? pz_hi : pz_lo) + dterm;
      below[k] = sum[k][SBits-1];
    end
    all_below = below[0] & below[1] & below[2] & below[3] &
                below[4] & below[5] & below[6] & below[7];
    c2_next = c1;
    c2_next.culled = c1.culled | all_below;
  end

  assign ctl_out = c2;
  assign lo_out  = lo2;
  assign hi_out  = hi2;

endmodule

### rtl/fbv_extent_cell.sv
// ----------------------------------------------------------------------------
// fbv_extent_cell: frustum corner extent test, last cell of the chain
// Holds the eight frustum corners and flags a box that lies wholly outside
// their span on any axis.
// ----------------------------------------------------------------------------
module fbv_extent_cell #(
  parameter int unsigned CoordBits = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  fbv_pkg::ctl_t               ctl_in,
  input  logic signed [CoordBits-1:0] lo_in [3],
  input  logic signed [CoordBits-1:0] hi_in [3],
  output logic                        out_valid,
  output fbv_pkg::cause_t             out_cause
);

  logic signed [CoordBits-1:0] corner [fbv_pkg::Corners][3];
  logic                        ld;
  logic                        ext;
  logic [2:0]                  axis_hit;

  assign ld = adv && ctl_in.cload;

  always_ff @(posedge clk) begin
    if (ld) begin
      corner[ctl_in.slot][0] <= lo_in[0];
      corner[ctl_in.slot][1] <= lo_in[1];
      corner[ctl_in.slot][2] <= lo_in[2];
    end
  end

  always_comb begin
    logic above, below;
    for (int ax = 0; ax < 3; ax++) begin
      above = 1'b1;
      below = 1'b1;
      for (int k = 0; k < fbv_pkg::Corners; k++) begin
        if (!(corner[k][ax] > hi_in[ax])) above = 1'b0;
        if (!(lo_in[ax] > corner[k][ax])) below = 1'b0;
      end
      axis_hit[ax] = above | below;
    end
    ext = |axis_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ctl_in.culled) out_cause <= fbv_pkg::CAUSE_PLANE;
      else if (ext)      out_cause <= fbv_pkg::CAUSE_EXTENT;
      else               out_cause <= fbv_pkg::CAUSE_VISIBLE;
    end
  end

endmodule

### rtl/frustum_box_visibility_core.sv
// ----------------------------------------------------------------------------
// frustum_box_visibility_core: frustum versus axis-aligned box culling
// Loads planes and frustum corners, then tests one box per cycle while the result channel does not stall.
// ----------------------------------------------------------------------------
// A request enters a chain of NUM_PLANES plane cells, each holding one plane
// and taking two register stages (products, then corner sums), and ends in
// one extent cell that registers the verdict. A new request is taken every
// cycle while no verdict is held waiting. The whole chain stalls only while
// the last verdict is not taken. Loads travel the chain in order with the
// tests, write the plane or corner store as they pass the cell that holds it,
// and give no result; every plane and corner must be loaded before the first
// test.
module frustum_box_visibility_core #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned NUM_PLANES = 6
) (
  input logic  clk,
  input logic  rst,
  fbv_req_if.sink   req,
  fbv_res_if.source res
);

  logic adv, acc, test_req;
  fbv_pkg::ctl_t               ctl [NUM_PLANES+1];
  logic signed [COORD_BITS-1:0] lo [NUM_PLANES+1][3];
  logic signed [COORD_BITS-1:0] hi [NUM_PLANES+1][3];
  logic                        last_valid;
  fbv_pkg::cause_t             last_cause;

  function automatic logic signed [COORD_BITS-1:0] cut(input logic [31:0] v);
    return COORD_BITS'(signed'(v));
  endfunction

  assign adv = !last_valid || res.ready;
  assign req.ready = adv;
  assign acc = req.valid && adv;
  assign test_req = (req.mode == fbv_pkg::MODE_TEST);

  assign ctl[0] = '{valid:  acc && test_req,
                    culled: 1'b0,
                    pload:  acc && (req.mode == fbv_pkg::MODE_PLANE),
                    cload:  acc && (req.mode == fbv_pkg::MODE_CORNER),
                    slot:   req.slot};
  assign lo[0][0] = test_req ? cut(req.box_min_x) : cut(req.coef_x);
  assign lo[0][1] = test_req ? cut(req.box_min_y) : cut(req.coef_y);
  assign lo[0][2] = test_req ? cut(req.box_min_z) : cut(req.coef_z);
  assign hi[0][0] = test_req ? cut(req.box_max_x) : cut(req.coef_w);
  assign hi[0][1] = cut(req.box_max_y);
  assign hi[0][2] = cut(req.box_max_z);

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    fbv_plane_cell #(.CoordBits(COORD_BITS), .Index(p)) u_cell (
      .clk, .rst, .adv,
      .ctl_in(ctl[p]), .lo_in(lo[p]), .hi_in(hi[p]),
      .ctl_out(ctl[p+1]), .lo_out(lo[p+1]), .hi_out(hi[p+1])
    );
  end

  fbv_extent_cell #(.CoordBits(COORD_BITS)) u_extent (
    .clk, .rst, .adv,
    .ctl_in(ctl[NUM_PLANES]), .lo_in(lo[NUM_PLANES]), .hi_in(hi[NUM_PLANES]),
    .out_valid(last_valid), .out_cause(last_cause)
  );

  assign res.valid      = last_valid;
  assign res.cull_cause = last_cause;
  assign res.visible    = (last_cause == fbv_pkg::CAUSE_VISIBLE);

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.cull_cause))
    else $error("verdict changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    req.ready == (!res.valid || res.ready))
    else $error("ready does not follow output stage");
  a_cause: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.cull_cause != fbv_pkg::CAUSE_RSVD)
    else $error("reserved cause");
  a_vis: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.visible == (res.cull_cause == fbv_pkg::CAUSE_VISIBLE))
    else $error("visible disagrees with cause");
`endif

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the frustum box visibility core
// Loads plane and corner sets while the core is idle, streams box tests with
// random gaps on both channels and checks every verdict against an exact
// wide-integer predictor of the plane sign test and the corner extent test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Planes  = 6;
  localparam int unsigned Latency = 2 * Planes + 1;
  localparam int unsigned Limit   = 400000;

  typedef struct {
    fbv_pkg::mode_t     mode;
    logic [2:0]         slot;
    logic signed [31:0] coef[4];
    logic signed [31:0] lo[3];
    logic signed [31:0] hi[3];
  } request_t;

  typedef struct {
    logic            visible;
    fbv_pkg::cause_t cause;
  } verdict_t;

  class verdict_board;
    logic signed [31:0] plane[Planes][4];
    logic signed [31:0] corner[fbv_pkg::Corners][3];
    verdict_t           pending[$];
    int                 errors = 0;

    function bit all_below(int p, logic signed [31:0] lo[3],
                           logic signed [31:0] hi[3]);
      logic signed [127:0] a, b, c, d, x, y, z, s;
      a = plane[p][0];
      b = plane[p][1];
      c = plane[p][2];
      d = plane[p][3];
      for (int k = 0; k < 8; k++) begin
        x = k[0] ? hi[0] : lo[0];
        y = k[1] ? hi[1] : lo[1];
        z = k[2] ? hi[2] : lo[2];
        s = a * x + b * y + c * z + (d <<< fbv_pkg::QShift);
        if (s >= 0) return 0;
      end
      return 1;
    endfunction

    function void note(request_t r);
      verdict_t v;
      bit above, under;
      case (r.mode)
        fbv_pkg::MODE_PLANE: begin
          if (r.slot < Planes) for (int k = 0; k < 4; k++) plane[r.slot][k] = r.coef[k];
        end
        fbv_pkg::MODE_CORNER: begin
          for (int k = 0; k < 3; k++) corner[r.slot][k] = r.coef[k];
        end
        fbv_pkg::MODE_TEST: begin
          v.cause = fbv_pkg::CAUSE_VISIBLE;
          for (int p = 0; p < Planes && v.cause == fbv_pkg::CAUSE_VISIBLE; p++)
            if (all_below(p, r.lo, r.hi)) v.cause = fbv_pkg::CAUSE_PLANE;
          for (int ax = 0; ax < 3 && v.cause == fbv_pkg::CAUSE_VISIBLE; ax++) begin
            above = 1;
            under = 1;
            for (int k = 0; k < fbv_pkg::Corners; k++) begin
              if (!(corner[k][ax] > r.hi[ax])) above = 0;
              if (!(r.lo[ax] > corner[k][ax])) under = 0;
            end
            if (above || under) v.cause = fbv_pkg::CAUSE_EXTENT;
          end
          v.visible = (v.cause == fbv_pkg::CAUSE_VISIBLE);
          pending.push_back(v);
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
    endtask

    task check(logic visible, logic [1:0] cause);
      verdict_t v;
      if (pending.size() == 0) begin
        report($sformatf("unexpected verdict visible=%0d cause=%0d", visible, cause));
      end else begin
        v = pending.pop_front();
        if (visible !== v.visible)
          report($sformatf("visible %0d, want %0d", visible, v.visible));
        if (cause !== v.cause)
          report($sformatf("cull_cause %0d, want %0d", cause, v.cause));
      end
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  bit   quiet = 0;
  bit   done = 0;
  int   cycles = 0;
  verdict_board board = new();

  fbv_req_if req();
  fbv_res_if res();

  frustum_box_visibility_core dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .res(res.source)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int stall;
    stall = 0;
    res.ready = 0;
    forever begin
      @(posedge clk);
      if (!rst && res.valid && res.ready) board.check(res.visible, res.cull_cause);
      if (stall > 0) begin
        stall--;
        res.ready <= 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(0, 7);
        res.ready <= 0;
      end else begin
        res.ready <= 1;
      end
    end
  end

  task automatic put(request_t r);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req.mode      <= r.mode;
    req.slot      <= r.slot;
    req.coef_x    <= r.coef[0];
    req.coef_y    <= r.coef[1];
    req.coef_z    <= r.coef[2];
    req.coef_w    <= r.coef[3];
    req.box_min_x <= r.lo[0];
    req.box_min_y <= r.lo[1];
    req.box_min_z <= r.lo[2];
    req.box_max_x <= r.hi[0];
    req.box_max_y <= r.hi[1];
    req.box_max_z <= r.hi[2];
    req.valid     <= 1;
    do @(posedge clk); while (!req.ready);
    board.note(r);
  endtask

  function automatic request_t blank(fbv_pkg::mode_t m, int s);
    request_t r;
    r.mode = m;
    r.slot = 3'(s);
    for (int k = 0; k < 4; k++) r.coef[k] = $urandom;
    for (int k = 0; k < 3; k++) begin
      r.lo[k] = $urandom;
      r.hi[k] = $urandom;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] near(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // drain the pipeline between load phases
  task automatic settle();
    req.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic put_plane(int s, int a, int b, int c, int d);
    request_t r;
    r = blank(fbv_pkg::MODE_PLANE, s);
    r.coef[0] = a;
    r.coef[1] = b;
    r.coef[2] = c;
    r.coef[3] = d;
    put(r);
  endtask

  task automatic put_box(int x0, int y0, int z0, int x1, int y1, int z1);
    request_t r;
    r = blank(fbv_pkg::MODE_TEST, $urandom_range(0, 7));
    r.lo[0] = x0; r.lo[1] = y0; r.lo[2] = z0;
    r.hi[0] = x1; r.hi[1] = y1; r.hi[2] = z1;
    put(r);
  endtask

  task automatic load_unit_cube(bit open_planes);
    request_t r;
    int one;
    one = 65536;
    for (int p = 0; p < Planes; p++) begin
      if (open_planes) put_plane(p, 0, 0, 0, one);
      else put_plane(p, (p == 0) ? one : (p == 1) ? -one : 0,
                     (p == 2) ? one : (p == 3) ? -one : 0,
                     (p == 4) ? one : (p == 5) ? -one : 0, one);
    end
    for (int k = 0; k < fbv_pkg::Corners; k++) begin
      r = blank(fbv_pkg::MODE_CORNER, k);
      r.coef[0] = k[0] ? one : -one;
      r.coef[1] = k[1] ? one : -one;
      r.coef[2] = k[2] ? one : -one;
      put(r);
    end
  endtask

  task automatic load_random_set(int span, bit wild);
    request_t r;
    int order[$];
    for (int s = 0; s < Planes + fbv_pkg::Corners; s++) order.push_back(s);
    order.shuffle();
    foreach (order[i]) begin
      if (order[i] < Planes) begin
        r = blank(fbv_pkg::MODE_PLANE, order[i]);
        if (!wild) begin
          for (int k = 0; k < 3; k++) r.coef[k] = near(65536);
          r.coef[3] = near(span);
        end
      end else begin
        r = blank(fbv_pkg::MODE_CORNER, order[i] - Planes);
        if (!wild) for (int k = 0; k < 3; k++) r.coef[k] = near(span);
      end
      put(r);
    end
  endtask

  task automatic random_tests(int count, int span, bit wild);
    request_t r;
    logic signed [31:0] c, h;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0: put(blank(fbv_pkg::MODE_NONE, $urandom_range(0, 7)));
        1: put(blank(fbv_pkg::MODE_PLANE, $urandom_range(Planes, 7)));
        2: put(blank(fbv_pkg::MODE_TEST, $urandom_range(0, 7)));
        default: begin
          r = blank(fbv_pkg::MODE_TEST, $urandom_range(0, 7));
          if (!wild) begin
            for (int k = 0; k < 3; k++) begin
              c = near(2 * span);
              h = $urandom_range(0, span / 2);
              r.lo[k] = c - h;
              r.hi[k] = ($urandom_range(0, 15) == 0) ? c - h - 1 : c + h;
            end
          end
          put(r);
        end
      endcase
    end
  endtask

  initial begin
    int maxv, minv;
    maxv = 32'h7fffffff;
    minv = 32'h80000000;
    req.valid = 0;
    req.mode = fbv_pkg::MODE_NONE;
    req.slot = 0;
    req.coef_x = 0; req.coef_y = 0; req.coef_z = 0; req.coef_w = 0;
    req.box_min_x = 0; req.box_min_y = 0; req.box_min_z = 0;
    req.box_max_x = 0; req.box_max_y = 0; req.box_max_z = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    load_unit_cube(0);
    put_plane(6, maxv, maxv, maxv, maxv);
    put_plane(7, minv, minv, minv, minv);
    put(blank(fbv_pkg::MODE_NONE, 3));
    put_box(-32768, -32768, -32768, 32768, 32768, 32768);
    put_box(5 << 16, 0, 0, 6 << 16, 1 << 16, 1 << 16);
    put_box(minv, minv, minv, maxv, maxv, maxv);
    put_box(32768, 0, 0, -32768, 0, 0);
    put_box(maxv, maxv, maxv, maxv, maxv, maxv);
    settle();

    load_unit_cube(1);
    put_box(2 << 16, 0, 0, 3 << 16, 0, 0);
    put_box(0, -(3 << 16), 0, 0, -(2 << 16), 0);
    put_box(minv, minv, minv, minv, minv, minv);
    put_box(-65536, -65536, -65536, 65536, 65536, 65536);
    settle();

    for (int k = 0; k < 4; k++) put_plane(k, maxv, minv, maxv, minv);
    put_plane(4, minv, minv, minv, minv);
    put_plane(5, maxv, maxv, maxv, maxv);
    put_box(minv, minv, minv, maxv, maxv, maxv);
    put_box(maxv, maxv, maxv, minv, minv, minv);
    put_box(minv, maxv, minv, minv, maxv, minv);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      load_random_set((ph % 3 == 0) ? (1 << 20) : (1 << 18), ph % 4 == 3);
      if (ph == 11) quiet = 1;
      random_tests(120, (ph % 3 == 0) ? (1 << 20) : (1 << 18), ph % 4 == 3);
      settle();
    end

    repeat (Latency + 10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
